FILE: rtl/mtg_pkg.sv
package mtg_pkg;

	localparam int TEETH_W   = 8;
	localparam int CLK_W     = 26;
	localparam int RPM_W     = 18;
	localparam int NOW_W     = 48;
	localparam int ANGLE_W   = 34;
	localparam int DELAY_W   = 25;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 26;

	// dividend is clock_hz*8, so three more bits than the clock register
	localparam int DVD_W = CLK_W + 3;

	// speeds below this (1 rpm in q4) count as stopped
	localparam logic [RPM_W-1:0] RPM_MIN = RPM_W'(16);
	// poll divisor while stopped
	localparam logic [RPM_W-1:0] IDLE_DIVISOR = RPM_W'(100);
	localparam logic [DELAY_W-1:0] DELAY_MIN = DELAY_W'(2);

	localparam logic [ANGLE_W-1:0] DEG_PER_REV = ANGLE_W'(360);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TOTAL_TEETH      = 3'd0,
		REG_MISSING_TEETH    = 3'd1,
		REG_CAM_ENABLE       = 3'd2,
		REG_CAM_START_SLOT   = 3'd3,
		REG_CAM_PULSE_LENGTH = 3'd4,
		REG_CLOCK_HZ         = 3'd5
	} reg_idx_t;

endpackage

FILE: rtl/mtg_if.sv
interface mtg_in_if;
	import mtg_pkg::*;

	logic              valid;
	logic              ready;
	logic              enable;
	logic [RPM_W-1:0]  rpm_q4;
	logic [NOW_W-1:0]  now_cycle;

	modport source (output valid, enable, rpm_q4, now_cycle, input ready);
	modport sink   (input valid, enable, rpm_q4, now_cycle, output ready);
endinterface

interface mtg_out_if;
	import mtg_pkg::*;

	logic                valid;
	logic                ready;
	logic                crank_level;
	logic                cam_level;
	logic [TEETH_W-1:0]  tooth_slot;
	logic                revolution_bit;
	logic [ANGLE_W-1:0]  crank_angle_deg;
	logic [DELAY_W-1:0]  delay_cycles;
	logic [NOW_W-1:0]    next_event_cycle;

	modport source (output valid, crank_level, cam_level, tooth_slot, revolution_bit,
		crank_angle_deg, delay_cycles, next_event_cycle, input ready);
	modport sink   (input valid, crank_level, cam_level, tooth_slot, revolution_bit,
		crank_angle_deg, delay_cycles, next_event_cycle, output ready);
endinterface

interface mtg_cfg_if;
	import mtg_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_ADDR_W-1:0]  addr;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/missing_tooth_crank_cam_generator.sv
// Missing-tooth crank wheel and cam signal generator.
// din carries one half-slot event (enable, rpm_q4, now_cycle); dout returns one
// word per event with the pin levels, the slot and revolution before the
// advance, the crank angle in degrees and the time of the next event.
// The user must write the six wheel registers only while idle; the block does
// not enforce it. cfg is always ready and drops writes past the last register.
// An accepted event is latched at the accepting edge; the bit-serial restoring
// divider then forms clock_hz*8/rpm_q4 (or clock_hz/100 while stopped) in
// S_DIV, and S_FIN loads the word into the dout register.
// The next event is accepted only after S_FIN has loaded that word, so a new
// event is never taken while the divider is still busy with the last one.
// A result word waits in the dout register while the receiver stalls; a
// second finished result then holds in the divider, which blocks new events.
// Reset clears the wheel counters, the handshakes and loads the registers with
// 60 teeth, 2 missing, cam off, cam slot 0, cam length 1 and 16 MHz.
module missing_tooth_crank_cam_generator #(
	parameter int CYCLE_COUNTER_BITS = 24,
	parameter int TIME_BITS          = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	mtg_in_if.sink           din,
	mtg_out_if.source        dout,
	mtg_cfg_if.sink          cfg
);
	import mtg_pkg::*;

	localparam int TW    = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
	localparam int CNT_W = $clog2(DVD_W);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;

	// configuration
	logic [TEETH_W-1:0] total_teeth_q, missing_teeth_q, cam_start_slot_q, cam_pulse_length_q;
	logic               cam_enable_q;
	logic [CLK_W-1:0]   clock_hz_q;

	// wheel state
	logic                          half_q, rev_q;
	logic [TEETH_W-1:0]            slot_q;
	logic [CYCLE_COUNTER_BITS-1:0] cycle_cnt_q;
	logic [ANGLE_W-1:0]            base_q;   // cycle*720 + rev*360

	// event in flight
	logic                crank_s1, cam_s1, rev_s1, idle_s1;
	logic [TEETH_W-1:0]  slot_s1;
	logic [ANGLE_W-1:0]  angle_s1;
	logic [TW-1:0]       now_s1;

	// divider
	logic [DVD_W-1:0]    dvd_q;
	logic [RPM_W-1:0]    dsor_q;
	logic [RPM_W-1:0]    rem_q;
	logic [DELAY_W-1:0]  quo_q;
	logic [CNT_W-1:0]    cnt_q;

	// output register
	logic                out_valid_q, out_crank_q, out_cam_q, out_rev_q;
	logic [TEETH_W-1:0]  out_slot_q;
	logic [ANGLE_W-1:0]  out_angle_q;
	logic [DELAY_W-1:0]  out_delay_q;
	logic [NOW_W-1:0]    out_next_q;

	logic                accept, stopped, load_out, out_take;
	logic [RPM_W:0]      trial, trial_sub;
	logic                qbit;
	logic [TEETH_W:0]    slot_inc, present_chk, cam_end;
	logic                crank_now, cam_now;
	logic [10:0]         slot_deg;
	logic [ANGLE_W-1:0]  angle_now;
	logic [CYCLE_COUNTER_BITS-1:0] cycle_inc;
	logic [DELAY_W-1:0]  delay_fin;
	logic [TW-1:0]       next_sum;

	assign din.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = din.valid && din.ready;
	assign stopped   = !din.enable || (din.rpm_q4 < RPM_MIN);

	assign slot_inc    = {1'b0, slot_q} + 1'b1;
	assign present_chk = {1'b0, slot_q} + {1'b0, missing_teeth_q};
	assign cam_end     = {1'b0, cam_start_slot_q} + {1'b0, cam_pulse_length_q};
	assign crank_now   = (present_chk < {1'b0, total_teeth_q}) && !half_q;
	assign cam_now     = cam_enable_q && !rev_q && (slot_q >= cam_start_slot_q)
		&& ({1'b0, slot_q} < cam_end);
	assign slot_deg    = 11'({slot_q, 2'b00}) + 11'({slot_q, 1'b0})
		+ (half_q ? 11'd3 : 11'd0);
	assign angle_now   = base_q + ANGLE_W'(slot_deg);
	assign cycle_inc   = cycle_cnt_q + 1'b1;

	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign trial_sub = trial - {1'b0, dsor_q};
	assign qbit      = !trial_sub[RPM_W];

	assign delay_fin = (!idle_s1 && quo_q < DELAY_MIN) ? DELAY_MIN : quo_q;
	assign next_sum  = now_s1 + TW'(delay_fin);

	assign load_out = (state_q == S_FIN) && (!out_valid_q || dout.ready);
	assign out_take = out_valid_q && dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_teeth_q      <= TEETH_W'(60);
			missing_teeth_q    <= TEETH_W'(2);
			cam_enable_q       <= 1'b0;
			cam_start_slot_q   <= '0;
			cam_pulse_length_q <= TEETH_W'(1);
			clock_hz_q         <= CLK_W'(16000000);
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_TOTAL_TEETH:      total_teeth_q      <= cfg.data[TEETH_W-1:0];
				REG_MISSING_TEETH:    missing_teeth_q    <= cfg.data[TEETH_W-1:0];
				REG_CAM_ENABLE:       cam_enable_q       <= cfg.data[0];
				REG_CAM_START_SLOT:   cam_start_slot_q   <= cfg.data[TEETH_W-1:0];
				REG_CAM_PULSE_LENGTH: cam_pulse_length_q <= cfg.data[TEETH_W-1:0];
				REG_CLOCK_HZ:         clock_hz_q         <= cfg.data[CLK_W-1:0];
				default: ;
			endcase
		end
	end

	// wheel counters advance on acceptance, after the outputs are sampled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			slot_q      <= '0;
			rev_q       <= 1'b0;
			cycle_cnt_q <= '0;
			base_q      <= '0;
		end else if (accept) begin
			if (stopped) begin
				half_q      <= 1'b0;
				slot_q      <= '0;
				rev_q       <= 1'b0;
				cycle_cnt_q <= '0;
				base_q      <= '0;
			end else if (!half_q) begin
				half_q <= 1'b1;
			end else begin
				half_q <= 1'b0;
				if (slot_inc >= {1'b0, total_teeth_q}) begin
					slot_q <= '0;
					rev_q  <= !rev_q;
					if (rev_q) begin
						cycle_cnt_q <= cycle_inc;
						base_q      <= (cycle_inc == '0) ? '0 : base_q + DEG_PER_REV;
					end else begin
						base_q <= base_q + DEG_PER_REV;
					end
				end else begin
					slot_q <= slot_inc[TEETH_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
						cnt_q   <= CNT_W'(DVD_W - 1);
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// event payload and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			idle_s1  <= stopped;
			crank_s1 <= stopped ? 1'b0 : crank_now;
			cam_s1   <= stopped ? 1'b0 : cam_now;
			slot_s1  <= stopped ? '0 : slot_q;
			rev_s1   <= stopped ? 1'b0 : rev_q;
			angle_s1 <= stopped ? '0 : angle_now;
			now_s1   <= din.now_cycle[TW-1:0];
			dvd_q    <= stopped ? DVD_W'(clock_hz_q) : {clock_hz_q, 3'b000};
			dsor_q   <= stopped ? IDLE_DIVISOR : din.rpm_q4;
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (state_q == S_DIV) begin
			// one quotient bit per cycle, MSB first
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= qbit ? trial_sub[RPM_W-1:0] : trial[RPM_W-1:0];
			quo_q <= {quo_q[DELAY_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_crank_q <= crank_s1;
			out_cam_q   <= cam_s1;
			out_slot_q  <= slot_s1;
			out_rev_q   <= rev_s1;
			out_angle_q <= angle_s1;
			out_delay_q <= delay_fin;
			out_next_q  <= NOW_W'(next_sum);
		end
	end

	assign dout.valid            = out_valid_q;
	assign dout.crank_level      = out_crank_q;
	assign dout.cam_level        = out_cam_q;
	assign dout.tooth_slot       = out_slot_q;
	assign dout.revolution_bit   = out_rev_q;
	assign dout.crank_angle_deg  = out_angle_q;
	assign dout.delay_cycles     = out_delay_q;
	assign dout.next_event_cycle = out_next_q;

endmodule

FILE: bench/tb.sv
module tb;
	import mtg_pkg::*;

	localparam int TURN_W = 24;
	localparam int EVENT_TARGET = 1900;
	// indexes past the last register; writes to them must be dropped
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic                crank;
		logic                cam;
		logic [TEETH_W-1:0]  slot;
		logic                rev;
		logic [ANGLE_W-1:0]  angle;
		logic [DELAY_W-1:0]  delay;
		logic [NOW_W-1:0]    nxt;
	} wheel_word_t;

	typedef enum bit {ROW_EVENT, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_ADDR_W-1:0]  idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   en;
		logic [RPM_W-1:0]       rpm;
		logic [NOW_W-1:0]       now;
		bit                     typed;
		wheel_word_t            want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	mtg_in_if  in_ch();
	mtg_out_if out_ch();
	mtg_cfg_if cfg_ch();

	missing_tooth_crank_cam_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(in_ch),
		.dout(out_ch),
		.cfg(cfg_ch)
	);

	// wheel position and register copies
	logic                half_q;
	logic [TEETH_W-1:0]  slot_q;
	logic                rev_q;
	logic [TURN_W-1:0]   turns_q;
	logic [TEETH_W-1:0]  teeth_r;
	logic [TEETH_W-1:0]  missing_r;
	logic                cam_en_r;
	logic [TEETH_W-1:0]  cam_start_r;
	logic [TEETH_W-1:0]  cam_len_r;
	logic [CLK_W-1:0]    hz_r;

	wheel_word_t wheel_words[$];
	plan_row_t   plan[$];
	int          fails = 0;
	int          events_sent = 0;
	bit          steady = 0;
	logic [NOW_W-1:0] last_next = '0;

	function automatic wheel_word_t wheel_advance(logic en, logic [RPM_W-1:0] rpm,
			logic [NOW_W-1:0] now);
		wheel_word_t w;
		int          present;
		logic [63:0] quot;
		logic [63:0] deg;
		w = '0;
		present = int'(teeth_r) - int'(missing_r);
		if (!en || rpm < RPM_MIN) begin
			half_q = 1'b0;
			slot_q = '0;
			rev_q = 1'b0;
			turns_q = '0;
			w.delay = DELAY_W'(hz_r / CLK_W'(IDLE_DIVISOR));
			w.nxt = now + NOW_W'(w.delay);
			return w;
		end
		w.crank = (int'(slot_q) < present) && !half_q;
		w.cam = cam_en_r && !rev_q && int'(slot_q) >= int'(cam_start_r) &&
			int'(slot_q) < int'(cam_start_r) + int'(cam_len_r);
		w.slot = slot_q;
		w.rev = rev_q;
		// 720 per engine cycle, 6 per slot, 3 per half slot
		deg = 64'(turns_q) * 64'd720 + 64'(rev_q) * 64'(DEG_PER_REV) +
			64'(slot_q) * 64'd6 + 64'(half_q) * 64'd3;
		w.angle = deg[ANGLE_W-1:0];
		quot = (64'(hz_r) * 64'd8) / 64'(rpm);
		if (quot < 64'(DELAY_MIN))
			quot = 64'(DELAY_MIN);
		w.delay = DELAY_W'(quot);
		w.nxt = now + NOW_W'(w.delay);

		if (!half_q) begin
			half_q = 1'b1;
		end else begin
			half_q = 1'b0;
			if (int'(slot_q) + 1 >= int'(teeth_r)) begin
				slot_q = '0;
				if (rev_q)
					turns_q = turns_q + 1'b1;
				rev_q = ~rev_q;
			end else begin
				slot_q = slot_q + 1'b1;
			end
		end
		return w;
	endfunction

	function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_TOTAL_TEETH:      teeth_r = data[TEETH_W-1:0];
			REG_MISSING_TEETH:    missing_r = data[TEETH_W-1:0];
			REG_CAM_ENABLE:       cam_en_r = data[0];
			REG_CAM_START_SLOT:   cam_start_r = data[TEETH_W-1:0];
			REG_CAM_PULSE_LENGTH: cam_len_r = data[TEETH_W-1:0];
			REG_CLOCK_HZ:         hz_r = data[CLK_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic wheel_word_t word_of(logic crank, logic cam, logic [TEETH_W-1:0] slot,
			logic rev, logic [ANGLE_W-1:0] angle, logic [DELAY_W-1:0] delay,
			logic [NOW_W-1:0] nxt);
		wheel_word_t w;
		w.crank = crank;
		w.cam = cam;
		w.slot = slot;
		w.rev = rev;
		w.angle = angle;
		w.delay = delay;
		w.nxt = nxt;
		return w;
	endfunction

	function automatic plan_row_t row_event(logic en, logic [RPM_W-1:0] rpm,
			logic [NOW_W-1:0] now, bit typed = 1'b0, wheel_word_t want = '0);
		plan_row_t r;
		r = '0;
		r.kind = ROW_EVENT;
		r.en = en;
		r.rpm = rpm;
		r.now = now;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t row_write(logic [CFG_ADDR_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			fails++;
		end
	endfunction

	task automatic send_event(logic en, logic [RPM_W-1:0] rpm, logic [NOW_W-1:0] now,
			bit typed = 1'b0, wheel_word_t want = '0);
		wheel_word_t w;
		int          gap;
		in_ch.valid <= 1'b1;
		in_ch.enable <= en;
		in_ch.rpm_q4 <= rpm;
		in_ch.now_cycle <= now;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		w = wheel_advance(en, rpm, now);
		wheel_words.push_back(typed ? want : w);
		last_next = w.nxt;
		events_sent++;
		gap = gap_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic reg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	// hold the event channel and wait for every pending word
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (wheel_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#24_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stalls, compare each word with the oldest expectation
	initial begin
		int          stall_left;
		wheel_word_t w;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (wheel_words.size() == 0) begin
					$error("result word arrived with nothing pending");
					fails++;
				end else begin
					w = wheel_words.pop_front();
					check_field("crank_level", 64'(w.crank), 64'(out_ch.crank_level));
					check_field("cam_level", 64'(w.cam), 64'(out_ch.cam_level));
					check_field("tooth_slot", 64'(w.slot), 64'(out_ch.tooth_slot));
					check_field("revolution_bit", 64'(w.rev), 64'(out_ch.revolution_bit));
					check_field("crank_angle_deg", 64'(w.angle),
						64'(out_ch.crank_angle_deg));
					check_field("delay_cycles", 64'(w.delay), 64'(out_ch.delay_cycles));
					check_field("next_event_cycle", 64'(w.nxt),
						64'(out_ch.next_event_cycle));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				stall_left = gap_len();
				out_ch.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		bit                  writing;
		int                  burst;
		int                  r;
		logic                en;
		logic [RPM_W-1:0]    rpm;
		logic [NOW_W-1:0]    now;
		logic [TEETH_W-1:0]  t_val;
		logic [TEETH_W-1:0]  m_val;
		logic [TEETH_W-1:0]  s_val;
		logic [TEETH_W-1:0]  l_val;
		logic [CLK_W-1:0]    hz_val;

		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.enable <= 1'b0;
		in_ch.rpm_q4 <= '0;
		in_ch.now_cycle <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= '0;
		cfg_ch.data <= '0;

		half_q = 1'b0;
		slot_q = '0;
		rev_q = 1'b0;
		turns_q = '0;
		teeth_r = 8'd60;
		missing_r = 8'd2;
		cam_en_r = 1'b0;
		cam_start_r = 8'd0;
		cam_len_r = 8'd1;
		hz_r = 26'd16000000;

		// stopped, below 1 rpm, slowest and fastest at the reset wheel
		plan.push_back(row_event(1'b0, '0, '0, 1'b1,
			word_of(1'b0, 1'b0, 8'd0, 1'b0, 34'd0, 25'd160000, 48'd160000)));
		plan.push_back(row_event(1'b1, RPM_W'(15), '1, 1'b1,
			word_of(1'b0, 1'b0, 8'd0, 1'b0, 34'd0, 25'd160000, 48'd159999)));
		plan.push_back(row_event(1'b1, RPM_MIN, NOW_W'(100), 1'b1,
			word_of(1'b1, 1'b0, 8'd0, 1'b0, 34'd0, 25'd8000000, 48'd8000100)));
		plan.push_back(row_event(1'b1, '1, '1, 1'b1,
			word_of(1'b0, 1'b0, 8'd0, 1'b0, 34'd3, 25'd488, 48'd487)));
		// two-slot wheel, more missing than total, cam over everything, fastest clock
		plan.push_back(row_write(REG_TOTAL_TEETH, 26'h3FFFF02));
		plan.push_back(row_write(REG_MISSING_TEETH, 26'd3));
		plan.push_back(row_write(REG_CAM_ENABLE, 26'h3FFFFFF));
		plan.push_back(row_write(REG_CAM_START_SLOT, 26'd0));
		plan.push_back(row_write(REG_CAM_PULSE_LENGTH, 26'd255));
		plan.push_back(row_write(REG_CLOCK_HZ, 26'd33554432));
		plan.push_back(row_write(REG_SPARE_A, '1));
		plan.push_back(row_write(REG_SPARE_B, '0));
		plan.push_back(row_event(1'b1, RPM_MIN, NOW_W'({$urandom, $urandom})));
		plan.push_back(row_event(1'b1, '1, NOW_W'({$urandom, $urandom})));
		plan.push_back(row_event(1'b1, RPM_W'(18'h15555), NOW_W'({$urandom, $urandom})));
		plan.push_back(row_event(1'b0, '1, NOW_W'({$urandom, $urandom})));
		// widest wheel with one present tooth, slowest clock
		plan.push_back(row_write(REG_TOTAL_TEETH, 26'd255));
		plan.push_back(row_write(REG_MISSING_TEETH, 26'd254));
		plan.push_back(row_write(REG_CAM_START_SLOT, 26'd254));
		plan.push_back(row_write(REG_CAM_PULSE_LENGTH, 26'd1));
		plan.push_back(row_write(REG_CLOCK_HZ, 26'd1000000));
		plan.push_back(row_event(1'b1, RPM_MIN, '0));
		plan.push_back(row_event(1'b1, RPM_W'(18'h2AAAA), '1));
		plan.push_back(row_event(1'b1, '1, NOW_W'(48'hAAAA_AAAA_AAAA)));
		plan.push_back(row_event(1'b1, RPM_W'(1000), NOW_W'(48'h5555_5555_5555)));
		// zero-length cam, then lower the total while slots are running
		plan.push_back(row_write(REG_TOTAL_TEETH, 26'd8));
		plan.push_back(row_write(REG_MISSING_TEETH, 26'd0));
		plan.push_back(row_write(REG_CAM_START_SLOT, 26'd2));
		plan.push_back(row_write(REG_CAM_PULSE_LENGTH, 26'd0));
		repeat (8)
			plan.push_back(row_event(1'b1, RPM_W'($urandom_range(16, 4000)),
				NOW_W'({$urandom, $urandom})));
		plan.push_back(row_write(REG_TOTAL_TEETH, 26'd3));
		repeat (3)
			plan.push_back(row_event(1'b1, RPM_W'($urandom_range(16, 4000)),
				NOW_W'({$urandom, $urandom})));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		writing = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!writing) begin
					settle();
					writing = 1'b1;
				end
				reg_write(plan[i].idx, plan[i].data);
			end else begin
				if (writing) begin
					cfg_ch.valid <= 1'b0;
					writing = 1'b0;
				end
				send_event(plan[i].en, plan[i].rpm, plan[i].now, plan[i].typed, plan[i].want);
			end
		end

		while (events_sent < EVENT_TARGET) begin
			settle();
			r = $urandom_range(0, 9);
			if (r == 0)
				t_val = 8'd2;
			else if (r == 1)
				t_val = 8'd255;
			else if (r == 2)
				t_val = TEETH_W'($urandom_range(17, 255));
			else
				t_val = TEETH_W'($urandom_range(2, 16));

			r = $urandom_range(0, 7);
			if (r == 0)
				m_val = 8'd0;
			else if (r == 1)
				m_val = 8'd254;
			else if (r == 2)
				m_val = (t_val < 8'd254) ? TEETH_W'($urandom_range(int'(t_val), 254)) : 8'd254;
			else
				m_val = TEETH_W'($urandom_range(0, int'(t_val) - 1));

			r = $urandom_range(0, 7);
			if (r == 0)
				s_val = 8'd255;
			else if (r == 1)
				s_val = TEETH_W'($urandom);
			else
				s_val = TEETH_W'($urandom_range(0, int'(t_val) - 1));

			r = $urandom_range(0, 9);
			if (r == 0)
				l_val = 8'd0;
			else if (r == 1)
				l_val = 8'd255;
			else if (r < 6)
				l_val = TEETH_W'($urandom_range(1, 3));
			else
				l_val = TEETH_W'($urandom_range(1, int'(t_val)));

			r = $urandom_range(0, 7);
			if (r == 0)
				hz_val = 26'd1000000;
			else if (r == 1)
				hz_val = 26'd33554432;
			else
				hz_val = CLK_W'($urandom_range(1000000, 33554432));

			// random bits above each narrower register's width must be dropped
			reg_write(REG_TOTAL_TEETH, {18'($urandom), t_val});
			reg_write(REG_MISSING_TEETH, {18'($urandom), m_val});
			reg_write(REG_CAM_ENABLE, {25'($urandom), 1'($urandom_range(0, 3) != 0)});
			reg_write(REG_CAM_START_SLOT, {18'($urandom), s_val});
			reg_write(REG_CAM_PULSE_LENGTH, {18'($urandom), l_val});
			reg_write(REG_CLOCK_HZ, hz_val);
			if ($urandom_range(0, 7) == 0)
				reg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom));
			cfg_ch.valid <= 1'b0;

			steady = ($urandom_range(0, 4) == 0);
			burst = $urandom_range(30, 150);
			repeat (burst) begin
				r = $urandom_range(0, 99);
				en = 1'b1;
				if (r < 4) begin
					en = 1'b0;
					rpm = RPM_W'($urandom);
				end else if (r < 7) begin
					rpm = RPM_W'($urandom_range(0, 15));
				end else if (r < 15) begin
					rpm = $urandom_range(0, 1) ? RPM_MIN : '1;
				end else begin
					rpm = RPM_W'($urandom_range(16, (1 << $urandom_range(5, 18)) - 1));
				end
				// mostly follow the schedule the block hands back
				now = ($urandom_range(0, 9) == 0) ? NOW_W'({$urandom, $urandom}) : last_next;
				send_event(en, rpm, now);
			end
			steady = 1'b0;
		end

		settle();
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
